// ----- rtl/pidfd_pkg.sv -----
// ============================================================================
// pidfd_pkg: shared types and constants of the filtered-derivative PID block
// Field widths, fixed-point constants, register map, state codes and the
// 48-bit state saturation used by the controller datapath.
// ============================================================================
`default_nettype none

package pidfd_pkg;

    // Field and datapath widths.
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int FRAC_W    = 16;
    localparam int DIFF_W    = IN_W + 1;
    localparam int ST_W      = 48;
    localparam int U_W       = OUT_W + FRAC_W;
    localparam int VAL_W     = 50;
    localparam int MCAND_W   = VAL_W;
    localparam int MPLR_W    = 24;
    localparam int PROD_W    = MCAND_W + MPLR_W;
    localparam int HI_W      = PROD_W - FRAC_W;
    localparam int SUM_W     = 60;
    localparam int CNT_W     = $clog2(MPLR_W);

    // Register port geometry.
    localparam int REG_IDX_W = 3;
    localparam int ADDR_W    = REG_IDX_W + 2;
    localparam int DATA_W    = 32;

    // Weight of the setpoint in the proportional path, Q15.16.
    localparam int SETPOINT_WEIGHT_Q16 = 65536;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_GAIN_K      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DERIV_DECAY = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WINDUP_GAIN = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_OUT_LOW     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_OUT_HIGH    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd7;

    // Controller configuration as seen by the datapath.
    typedef struct packed {
        logic signed [23:0] gain_k;
        logic        [16:0] deriv_decay;
        logic signed [23:0] deriv_gain;
        logic signed [23:0] integ_gain;
        logic        [22:0] windup_gain;
        logic signed [15:0] out_low;
        logic signed [15:0] out_high;
        logic        [14:0] integ_limit;
    } cfg_t;

    // Which actuator bound was applied.
    typedef enum logic [1:0] {
        LIM_NONE = 2'd0,
        LIM_LOW  = 2'd1,
        LIM_HIGH = 2'd2
    } lim_code_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_VSUM,
        ST_CLAMP,
        ST_DIFF,
        ST_MUL3
    } state_t;

    // Saturate a wide sum to the signed 48-bit state range.
    function automatic logic signed [ST_W-1:0] sat_state(input logic signed [SUM_W-1:0] x);
        logic [SUM_W-ST_W:0] top;
        top = x[SUM_W-1:ST_W-1];
        if (top == '0 || top == '1) begin
            sat_state = x[ST_W-1:0];
        end else if (x[SUM_W-1]) begin
            sat_state = {1'b1, {(ST_W-1){1'b0}}};
        end else begin
            sat_state = {1'b0, {(ST_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pidfd_regs.sv -----
// ============================================================================
// pidfd_regs: configuration register file
// APB-style write and read access to the eight controller registers, with
// their reset values, presented to the datapath as one structure.
// ============================================================================
`default_nettype none

module pidfd_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pidfd_pkg::ADDR_W-1:0]    paddr,
    input  logic [pidfd_pkg::DATA_W-1:0]    pwdata,
    output logic [pidfd_pkg::DATA_W-1:0]    prdata,
    output logic                            pready,
    output pidfd_pkg::cfg_t                 cfg
);
    import pidfd_pkg::*;

    cfg_t                   cfg_reg;
    cfg_t                   cfg_next;
    logic                   wr_en;
    logic [REG_IDX_W-1:0]   idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    // Register write decode.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_GAIN_K:      cfg_next.gain_k      = pwdata[23:0];
                REG_DERIV_DECAY: cfg_next.deriv_decay = pwdata[16:0];
                REG_DERIV_GAIN:  cfg_next.deriv_gain  = pwdata[23:0];
                REG_INTEG_GAIN:  cfg_next.integ_gain  = pwdata[23:0];
                REG_WINDUP_GAIN: cfg_next.windup_gain = pwdata[22:0];
                REG_OUT_LOW:     cfg_next.out_low     = pwdata[15:0];
                REG_OUT_HIGH:    cfg_next.out_high    = pwdata[15:0];
                REG_INTEG_LIMIT: cfg_next.integ_limit = pwdata[14:0];
                default: begin
                end
            endcase
        end
    end

    // Register storage with reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_k      <= 24'sd65536;
            cfg_reg.deriv_decay <= '0;
            cfg_reg.deriv_gain  <= '0;
            cfg_reg.integ_gain  <= '0;
            cfg_reg.windup_gain <= '0;
            cfg_reg.out_low     <= -16'sd10000;
            cfg_reg.out_high    <= 16'sd10000;
            cfg_reg.integ_limit <= 15'd500;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux; values are returned as their raw bits.
    always_comb begin
        case (idx)
            REG_GAIN_K:      prdata = DATA_W'($unsigned(cfg_reg.gain_k));
            REG_DERIV_DECAY: prdata = DATA_W'(cfg_reg.deriv_decay);
            REG_DERIV_GAIN:  prdata = DATA_W'($unsigned(cfg_reg.deriv_gain));
            REG_INTEG_GAIN:  prdata = DATA_W'($unsigned(cfg_reg.integ_gain));
            REG_WINDUP_GAIN: prdata = DATA_W'(cfg_reg.windup_gain);
            REG_OUT_LOW:     prdata = DATA_W'($unsigned(cfg_reg.out_low));
            REG_OUT_HIGH:    prdata = DATA_W'($unsigned(cfg_reg.out_high));
            REG_INTEG_LIMIT: prdata = DATA_W'(cfg_reg.integ_limit);
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/pidfd_mul.sv -----
// ============================================================================
// pidfd_mul: bit-serial signed multiplier
// Shift-add multiplier that consumes one multiplier bit per cycle, least
// significant first; the last bit carries negative weight.
// ============================================================================
`default_nettype none

module pidfd_mul (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    start,
    input  logic signed [pidfd_pkg::MCAND_W-1:0]    mcand,
    input  logic signed [pidfd_pkg::MPLR_W-1:0]     mplr,
    output logic                                    busy,
    output logic signed [pidfd_pkg::PROD_W-1:0]     product
);
    import pidfd_pkg::*;

    logic                       busy_reg;
    logic                       busy_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;
    logic signed [MCAND_W:0]    acc_reg;
    logic signed [MCAND_W:0]    acc_next;
    logic [MPLR_W-1:0]          mplr_reg;
    logic [MPLR_W-1:0]          mplr_next;
    logic signed [MCAND_W-1:0]  mcand_reg;
    logic signed [MCAND_W-1:0]  mcand_next;
    logic signed [MCAND_W:0]    addend;
    logic signed [MCAND_W:0]    sum;
    logic                       last;

    // One partial product per cycle; the sign bit of the multiplier subtracts.
    always_comb begin
        addend = mplr_reg[0] ? (MCAND_W+1)'(mcand_reg) : '0;
        last   = (cnt_reg == CNT_W'(MPLR_W - 1));
        sum    = last ? (acc_reg - addend) : (acc_reg + addend);
    end

    // Iteration control.
    always_comb begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mplr_next  = mplr_reg;
        mcand_next = mcand_reg;
        if (!busy_reg) begin
            if (start) begin
                busy_next  = 1'b1;
                cnt_next   = '0;
                acc_next   = '0;
                mplr_next  = mplr;
                mcand_next = mcand;
            end
        end else begin
            acc_next  = sum >>> 1;
            mplr_next = {sum[0], mplr_reg[MPLR_W-1:1]};
            cnt_next  = cnt_reg + CNT_W'(1);
            if (last) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg   <= acc_next;
        mplr_reg  <= mplr_next;
        mcand_reg <= mcand_next;
    end

    assign busy    = busy_reg;
    assign product = $signed({acc_reg[MCAND_W-1:0], mplr_reg});

endmodule

`default_nettype wire

// ----- rtl/pid_filtered_derivative.sv -----
// Sequence: each input word runs three passes of the bit-serial multipliers
// (one cycle per gain bit), with add, clamp and state update steps between
// them. A new input word is accepted only once the previous word is done, and
// the clamp step waits until the previous result word has been taken.
// Reset: aresetn is synchronous and active low; it clears the filter states,
// the handshakes and loads the default register values.
// ============================================================================
// pid_filtered_derivative: fixed-point PID step with filtered derivative
// Computes P, a filtered D and a back-calculated I with two bit-serial
// multipliers, clamps the output to the actuator limits and updates state.
// ============================================================================
`default_nettype none

module pid_filtered_derivative (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pidfd_pkg::ADDR_W-1:0]        paddr,
    input  logic [pidfd_pkg::DATA_W-1:0]        pwdata,
    output logic [pidfd_pkg::DATA_W-1:0]        prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [pidfd_pkg::IN_W-1:0]   s_setpoint,
    input  logic signed [pidfd_pkg::IN_W-1:0]   s_measured,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [pidfd_pkg::OUT_W-1:0]  m_drive,
    output logic [1:0]                          m_limit_hit
);
    import pidfd_pkg::*;

    localparam logic signed [MCAND_W-1:0] SP_WEIGHT = MCAND_W'(SETPOINT_WEIGHT_Q16);

    cfg_t                       cfg;
    state_t                     state_reg;
    state_t                     state_next;

    // Controller state.
    logic signed [ST_W-1:0]     d_reg;
    logic signed [ST_W-1:0]     i_reg;
    logic signed [IN_W-1:0]     lm_reg;

    // Per-word working registers.
    logic signed [DIFF_W-1:0]   dy_reg;
    logic signed [DIFF_W-1:0]   ew_reg;
    logic signed [VAL_W-1:0]    p_reg;
    logic signed [VAL_W-1:0]    dd_reg;
    logic signed [VAL_W-1:0]    ibi_reg;
    logic signed [VAL_W-1:0]    pi_reg;
    logic signed [VAL_W-1:0]    v_reg;
    logic signed [VAL_W-1:0]    t_reg;
    logic signed [U_W-1:0]      u_reg;

    // Result word register.
    logic                       m_valid_reg;
    logic signed [OUT_W-1:0]    drive_reg;
    lim_code_t                  lim_reg;

    // Sequencer strobes.
    logic                       take_in;
    logic                       end_p1;
    logic                       end_p2;
    logic                       do_vsum;
    logic                       do_clamp;
    logic                       do_diff;
    logic                       end_p3;
    logic                       mul_idle;

    // Multiplier ports.
    logic                       a_start;
    logic                       b_start;
    logic signed [MCAND_W-1:0]  a_mcand;
    logic signed [MCAND_W-1:0]  b_mcand;
    logic signed [MPLR_W-1:0]   a_mplr;
    logic signed [MPLR_W-1:0]   b_mplr;
    logic                       a_busy;
    logic                       b_busy;
    logic signed [PROD_W-1:0]   a_prod;
    logic signed [PROD_W-1:0]   b_prod;
    logic signed [HI_W-1:0]     a_hi;
    logic signed [HI_W-1:0]     b_hi;

    // Combinational datapath values.
    logic signed [MCAND_W-1:0]  a_full;
    logic signed [DIFF_W-1:0]   dy_in;
    logic signed [DIFF_W-1:0]   ew_in;
    logic signed [ST_W-1:0]     lim_q;
    logic                       i_over;
    logic signed [U_W-1:0]      lo_u;
    logic signed [U_W-1:0]      hi_u;
    logic signed [U_W-1:0]      u_val;
    lim_code_t                  lim_val;
    logic signed [SUM_W-1:0]    d_sum;
    logic signed [SUM_W-1:0]    i_sum;

    pidfd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pidfd_mul u_mul_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (a_start),
        .mcand   (a_mcand),
        .mplr    (a_mplr),
        .busy    (a_busy),
        .product (a_prod)
    );

    pidfd_mul u_mul_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (b_start),
        .mcand   (b_mcand),
        .mplr    (b_mplr),
        .busy    (b_busy),
        .product (b_prod)
    );

    // Input word terms and the integrator limit check.
    always_comb begin
        a_full = MCAND_W'(s_setpoint) * SP_WEIGHT - (MCAND_W'(s_measured) <<< FRAC_W);
        dy_in  = DIFF_W'(s_measured) - DIFF_W'(lm_reg);
        ew_in  = DIFF_W'(s_setpoint) - DIFF_W'(s_measured);
        lim_q  = ST_W'({cfg.integ_limit, {FRAC_W{1'b0}}});
        i_over = (i_reg > lim_q) || (i_reg < -lim_q);
    end

    // Product scaling: dropping 16 fraction bits floors the value.
    assign a_hi = a_prod[PROD_W-1:FRAC_W];
    assign b_hi = b_prod[PROD_W-1:FRAC_W];

    // Derivative and integrator update sums before saturation.
    always_comb begin
        d_sum = SUM_W'(dd_reg) - SUM_W'($signed(a_prod[VAL_W-1:0]));
        i_sum = SUM_W'(t_reg) + SUM_W'(a_hi);
    end

    // Output clamp; the low bound is checked first and wins for values below it, even when it is above the high bound.
    always_comb begin
        lo_u = {cfg.out_low, {FRAC_W{1'b0}}};
        hi_u = {cfg.out_high, {FRAC_W{1'b0}}};
        if (v_reg < VAL_W'(lo_u)) begin
            u_val   = lo_u;
            lim_val = LIM_LOW;
        end else if (v_reg > VAL_W'(hi_u)) begin
            u_val   = hi_u;
            lim_val = LIM_HIGH;
        end else begin
            u_val   = U_W'(v_reg);
            lim_val = LIM_NONE;
        end
    end

    // Multiplier operand selection per pass.
    always_comb begin
        case (state_reg)
            ST_MUL1: begin
                a_mcand = MCAND_W'(dy_reg);
                a_mplr  = cfg.deriv_gain;
                b_mcand = MCAND_W'(ew_reg);
                b_mplr  = cfg.integ_gain;
            end
            ST_DIFF: begin
                a_mcand = VAL_W'(u_reg) - v_reg;
                a_mplr  = $signed(MPLR_W'(cfg.windup_gain));
                b_mcand = MCAND_W'(d_reg);
                b_mplr  = $signed(MPLR_W'(cfg.deriv_decay));
            end
            default: begin
                a_mcand = a_full;
                a_mplr  = cfg.gain_k;
                b_mcand = MCAND_W'(d_reg);
                b_mplr  = $signed(MPLR_W'(cfg.deriv_decay));
            end
        endcase
    end

    assign mul_idle = !a_busy && !b_busy;

    // Sequencer: next state and strobes.
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        take_in    = 1'b0;
        end_p1     = 1'b0;
        end_p2     = 1'b0;
        do_vsum    = 1'b0;
        do_clamp   = 1'b0;
        do_diff    = 1'b0;
        end_p3     = 1'b0;
        a_start    = 1'b0;
        b_start    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    take_in    = 1'b1;
                    a_start    = 1'b1;
                    b_start    = 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: begin
                if (mul_idle) begin
                    end_p1     = 1'b1;
                    a_start    = 1'b1;
                    b_start    = 1'b1;
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2: begin
                if (mul_idle) begin
                    end_p2     = 1'b1;
                    state_next = ST_VSUM;
                end
            end
            ST_VSUM: begin
                do_vsum    = 1'b1;
                state_next = ST_CLAMP;
            end
            ST_CLAMP: begin
                if (!m_valid_reg || m_ready) begin
                    do_clamp   = 1'b1;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                do_diff    = 1'b1;
                a_start    = 1'b1;
                state_next = ST_MUL3;
            end
            ST_MUL3: begin
                if (mul_idle) begin
                    end_p3     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Filter state: the integrator is cleared on entry when it is beyond the limit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg  <= '0;
            i_reg  <= '0;
            lm_reg <= '0;
        end else begin
            if (take_in) begin
                lm_reg <= s_measured;
                if (i_over) begin
                    i_reg <= '0;
                end
            end
            if (end_p2) begin
                d_reg <= sat_state(d_sum);
            end
            if (end_p3) begin
                i_reg <= sat_state(i_sum);
            end
        end
    end

    // Working registers along the sequence.
    always_ff @(posedge aclk) begin
        if (take_in) begin
            dy_reg <= dy_in;
            ew_reg <= ew_in;
        end
        if (end_p1) begin
            p_reg  <= VAL_W'(a_hi);
            dd_reg <= VAL_W'(b_hi);
        end
        if (end_p2) begin
            ibi_reg <= $signed(b_prod[VAL_W-1:0]);
            pi_reg  <= p_reg + VAL_W'(i_reg);
        end
        if (do_vsum) begin
            v_reg <= pi_reg + VAL_W'(d_reg);
        end
        if (do_clamp) begin
            u_reg <= u_val;
        end
        if (do_diff) begin
            t_reg <= VAL_W'(i_reg) + ibi_reg;
        end
    end

    // Result word register; a new word loads only once the previous one is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (do_clamp) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_clamp) begin
            drive_reg <= u_val[U_W-1:FRAC_W];
            lim_reg   <= lim_val;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_drive     = drive_reg;
    assign m_limit_hit = lim_reg;

endmodule

`default_nettype wire

// ----- rtl/pidfd_chk.sv -----
// ============================================================================
// pidfd_chk: port-level checker for the PID block
// Watches the word handshakes over time and is bound to the top level.
// ============================================================================
`default_nettype none

module pidfd_chk (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_valid,
    input logic         s_ready,
    input logic         m_valid,
    input logic         m_ready,
    input logic [15:0]  m_drive,
    input logic [1:0]   m_limit_hit
);

    // A result word that is not taken stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive) && $stable(m_limit_hit))
        else $error("result word changed or dropped while stalled");

    // The block works on one word at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted again right after an accepted word");

    // A result only appears while a word is still being processed.
    a_result_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !s_ready)
        else $error("result word appeared while the block was idle");

    // Reset leaves the block idle with no pending result.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind pid_filtered_derivative pidfd_chk u_pidfd_chk (.*);

`default_nettype wire
